// ===== rtl/core/fpa_pkg.sv =====
// shared types and constants for the q24.8 fixed-point alu
`default_nettype none
package fpa_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MAX      = 4'd10,
        OP_MIN      = 4'd11,
        OP_FROM_INT = 4'd12,
        OP_TO_INT   = 4'd13,
        OP_INC      = 4'd14,
        OP_DEC      = 4'd15
    } fpa_op_t;

    typedef struct packed {
        fpa_op_t                       kind;
        logic signed [WORD_BITS-1:0]   operand_a;
        logic signed [WORD_BITS-1:0]   operand_b;
    } fpa_in_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0]   result_word;
        logic                          flag;
    } fpa_out_t;

    // state handed from one divide cell to the next
    typedef struct packed {
        logic                          is_div;
        logic                          neg;
        logic [WORD_BITS-1:0]          divisor;
        logic [WORD_BITS-1:0]          rem;
        logic [DIV_STEPS-1:0]          dq;
        logic [WORD_BITS-1:0]          result_word;
        logic                          flag;
    } fpa_cell_t;

endpackage
`default_nettype wire

// ===== rtl/core/fpa_entry.sv =====
// entry stage: operand decode, all non-divide operations and divide setup
`default_nettype none
module fpa_entry
    import fpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire fpa_in_t   req,
    output logic           out_valid,
    input  wire logic      out_ready,
    output fpa_cell_t      out_data
);

    logic                        valid_reg;
    logic                        valid_next;
    fpa_cell_t                   data_reg;
    fpa_cell_t                   data_next;
    logic signed [WORD_BITS-1:0] a;
    logic signed [WORD_BITS-1:0] b;
    logic signed [2*WORD_BITS-1:0] prod;
    logic                        a_lt_b;
    logic                        b_lt_a;
    logic                        a_eq_b;
    logic                        take;

    assign a      = req.operand_a;
    assign b      = req.operand_b;
    assign prod   = a * b;
    assign a_lt_b = a < b;
    assign b_lt_a = b < a;
    assign a_eq_b = a == b;

    assign req_ready = !valid_reg || out_ready;
    assign take      = req_valid && req_ready;

    always_comb
    begin
        data_next             = '0;
        data_next.result_word = '0;
        data_next.flag        = 1'b0;
        unique case (req.kind)
            OP_ADD:      data_next.result_word = a + b;
            OP_SUB:      data_next.result_word = a - b;
            OP_MUL:      data_next.result_word = prod[WORD_BITS+FRAC_BITS-1:FRAC_BITS];
            OP_DIV:
            begin
                if (b == '0)
                begin
                    data_next.flag = 1'b1;
                end
                else
                begin
                    data_next.is_div  = 1'b1;
                    data_next.neg     = a[WORD_BITS-1] ^ b[WORD_BITS-1];
                    data_next.divisor = b[WORD_BITS-1] ? WORD_BITS'(-b) : b;
                    data_next.dq      = {(a[WORD_BITS-1] ? WORD_BITS'(-a) : a),
                                         {FRAC_BITS{1'b0}}};
                end
            end
            OP_GT:       data_next.flag = b_lt_a;
            OP_LT:       data_next.flag = a_lt_b;
            OP_GE:       data_next.flag = !a_lt_b;
            OP_LE:       data_next.flag = !b_lt_a;
            OP_EQ:       data_next.flag = a_eq_b;
            OP_NE:       data_next.flag = !a_eq_b;
            OP_MAX:      data_next.result_word = b_lt_a ? a : b;
            OP_MIN:      data_next.result_word = a_lt_b ? a : b;
            OP_FROM_INT: data_next.result_word = {a[WORD_BITS-FRAC_BITS-1:0],
                                                  {FRAC_BITS{1'b0}}};
            OP_TO_INT:   data_next.result_word = a >>> FRAC_BITS;
            OP_INC:      data_next.result_word = a + WORD_BITS'(1);
            OP_DEC:      data_next.result_word = a - WORD_BITS'(1);
            default:     data_next.result_word = '0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (req_ready)
        begin
            valid_next = req_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/fpa_div_cell.sv =====
// one restoring-division cell: one quotient bit per beat
`default_nettype none
module fpa_div_cell
    import fpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire fpa_cell_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output fpa_cell_t      out_data
);

    logic                  valid_reg;
    logic                  valid_next;
    fpa_cell_t             data_reg;
    fpa_cell_t             data_next;
    logic [WORD_BITS:0]    trial;
    logic                  fits;
    logic                  take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // shift the next dividend bit into the partial remainder
    assign trial = {in_data.rem, in_data.dq[DIV_STEPS-1]};
    assign fits  = trial >= {1'b0, in_data.divisor};

    always_comb
    begin
        data_next     = in_data;
        data_next.rem = fits ? WORD_BITS'(trial - {1'b0, in_data.divisor})
                             : trial[WORD_BITS-1:0];
        data_next.dq  = {in_data.dq[DIV_STEPS-2:0], fits};
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/fixed_point_q24_8_alu.sv =====
// q24.8 fixed-point alu: entry stage, chain of 40 division cells, output register
// throughput: one beat per cycle while rsp_ready is not held low; the division chain retires one quotient bit per cell
// each stage holds its beat while the next one cannot take it, so bubbles close up
// reset: rst_n async active low clears all stage valid bits; no other state
`default_nettype none
module fixed_point_q24_8_alu
    import fpa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire fpa_in_t  req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output fpa_out_t      rsp
);

    logic      chain_valid [DIV_STEPS+1];
    logic      chain_ready [DIV_STEPS+1];
    fpa_cell_t chain_data  [DIV_STEPS+1];

    logic      valid_reg;
    logic      valid_next;
    fpa_out_t  rsp_reg;
    fpa_out_t  rsp_next;
    logic      last_ready;
    logic      take;
    fpa_cell_t last;

    fpa_entry u_entry (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        fpa_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    assign last       = chain_data[DIV_STEPS];
    assign last_ready = !valid_reg || rsp_ready;
    assign chain_ready[DIV_STEPS] = last_ready;
    assign take       = chain_valid[DIV_STEPS] && last_ready;

    // fix the quotient sign on the way out
    always_comb
    begin
        rsp_next.result_word = last.result_word;
        rsp_next.flag        = last.flag;
        if (last.is_div)
        begin
            rsp_next.result_word = last.neg ? -last.dq[WORD_BITS-1:0]
                                            : last.dq[WORD_BITS-1:0];
            rsp_next.flag        = 1'b0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (last_ready)
        begin
            valid_next = chain_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire
